>>> rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg
// Shared types and constants of the Reno-style congestion window controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

    localparam int ACK_W      = 16;
    localparam int WIN_W      = 10;
    localparam int CFG_W      = 10;
    localparam int LIMIT_W    = 4;
    localparam int ADDR_W     = 2;
    localparam int SLIDE_W    = 16;
    localparam int SEQ_OUT_W  = 16;
    localparam int LAST_W     = ACK_W + 1;
    localparam int DIVIDEND_W = ACK_W + 1;
    localparam int DIV_CNT_W  = 5;
    localparam int DIV_STEPS  = DIVIDEND_W;

    localparam int WIN_HW_MAX = 1023;

    localparam logic [CFG_W-1:0]   THR_RESET   = 10'd20;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;
    localparam logic [LIMIT_W-1:0] DUP_SAT     = 4'd15;
    localparam logic [LAST_W-1:0]  NONE_ACKED  = 17'h1FFFF;
    localparam logic [WIN_W-1:0]   RECOV_BUMP  = 10'd3;

    localparam logic [ADDR_W-1:0] CFG_INIT_THR  = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_DUP_LIMIT = 2'd1;

    localparam logic CMD_ACK     = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        PH_SS = 2'd0,
        PH_CA = 2'd1,
        PH_FR = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IGNORED = 2'd0,
        ST_NEW     = 2'd1,
        ST_DUP     = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/rcw_if.sv
// ----------------------------------------------------------------------------
// rcw_if
// Valid/ready channels of the congestion window controller: event requests,
// result requests and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcw_evt_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [rcw_pkg::ACK_W-1:0]  ack_num;
    logic                       ack_valid;

    modport source (output valid, output cmd, output ack_num, output ack_valid,
                    input ready);
    modport sink   (input valid, input cmd, input ack_num, input ack_valid,
                    output ready);
endinterface

interface rcw_res_if;
    logic                           valid;
    logic                           ready;
    logic [rcw_pkg::WIN_W-1:0]      window;
    logic [rcw_pkg::WIN_W-1:0]      threshold;
    logic [1:0]                     phase;
    logic [rcw_pkg::SEQ_OUT_W-1:0]  base_seq;
    logic [rcw_pkg::SLIDE_W-1:0]    slide_count;
    logic                           resend_all;
    logic [1:0]                     event_status;

    modport source (output valid, output window, output threshold, output phase,
                    output base_seq, output slide_count, output resend_all,
                    output event_status, input ready);
    modport sink   (input valid, input window, input threshold, input phase,
                    input base_seq, input slide_count, input resend_all,
                    input event_status, output ready);
endinterface

interface rcw_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rcw_pkg::ADDR_W-1:0] addr;
    logic [rcw_pkg::CFG_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rcw_div.sv
// ----------------------------------------------------------------------------
// rcw_div
// Serial restoring divider: one quotient bit per cycle, acked count / window.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [rcw_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  wire logic [rcw_pkg::WIN_W-1:0]          i_divisor,
    output logic                                    o_done,
    output logic [rcw_pkg::DIVIDEND_W-1:0]          o_quot
);

    logic                               r_busy;
    logic                               r_done;
    logic [rcw_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [rcw_pkg::WIN_W-1:0]          r_rem;
    logic [rcw_pkg::WIN_W-1:0]          r_div;
    logic [rcw_pkg::DIVIDEND_W-1:0]     r_quot;

    logic [rcw_pkg::WIN_W:0]            rem_sh;
    logic [rcw_pkg::WIN_W:0]            rem_sub;
    logic                               fits;

    always_comb begin
        rem_sh  = {r_rem, r_quot[rcw_pkg::DIVIDEND_W-1]};
        fits    = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quot <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= fits ? rem_sub[rcw_pkg::WIN_W-1:0] : rem_sh[rcw_pkg::WIN_W-1:0];
                r_quot <= {r_quot[rcw_pkg::DIVIDEND_W-2:0], fits};
                if (r_cnt == rcw_pkg::DIV_CNT_W'(rcw_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + rcw_pkg::DIV_CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> rtl/reno_congestion_window.sv
// ----------------------------------------------------------------------------
// reno_congestion_window
// Reno-style sender congestion controller: slow start, avoidance and fast
// recovery window tracking driven by ACK and retransmission-timeout events.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one event request (cmd, ack_num, ack_valid); i_evt.ready
//   is high only while the block is idle, so one event is in work at a time.
//   o_res carries one result request per event: window, threshold, phase,
//   base_seq, slide_count, resend_all, event_status, all after the event.
//   i_cfg writes addr 0 (initial threshold, also loads the live threshold)
//   and addr 1 (duplicate ACK limit); it is always ready, other addresses
//   are dropped. Write it only while no event is in work.
//   From accept to result valid an event passes S_CALC and S_OUT; a new
//   ACK in congestion avoidance also passes S_DIV, where the serial divider
//   forms acked count / window one quotient bit at a time.
//   A new event is accepted only once the last one has left S_OUT.
//   Reset (synchronous, active low) restores slow start, window 1,
//   threshold 20, dup limit 3, nothing acked, base 0.
//   The result sits in an output register; if the receiver stalls, the next
//   event is still accepted and processed, and its result waits until the
//   pending one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module reno_congestion_window #(
    parameter int MAX_WINDOW = 1023,
    parameter int SEQ_BITS   = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rcw_evt_if.sink     i_evt,
    rcw_res_if.source   o_res,
    rcw_cfg_if.sink     i_cfg
);

    localparam int BASE_W = (SEQ_BITS < rcw_pkg::LAST_W) ? SEQ_BITS : rcw_pkg::LAST_W;
    localparam logic [rcw_pkg::WIN_W-1:0] WIN_CAP =
        rcw_pkg::WIN_W'((MAX_WINDOW < rcw_pkg::WIN_HW_MAX) ? MAX_WINDOW : rcw_pkg::WIN_HW_MAX);

    localparam int LW = rcw_pkg::LAST_W;
    localparam int WW = rcw_pkg::WIN_W;
    localparam int SW = WW + LW + 1;

    function automatic logic [WW-1:0] cap_win(input logic [SW-1:0] w);
        logic [WW-1:0] res;
        if (w > SW'(WIN_CAP)) begin
            res = WIN_CAP;
        end else if (w == '0) begin
            res = WW'(1);
        end else begin
            res = w[WW-1:0];
        end
        return res;
    endfunction

    rcw_pkg::t_state  r_state, n_state;

    logic                           r_cmd;
    logic [rcw_pkg::ACK_W-1:0]      r_ack;
    logic                           r_ackv;

    rcw_pkg::t_phase                r_phase, n_phase;
    logic [WW-1:0]                  r_window, n_window;
    logic [rcw_pkg::CFG_W-1:0]      r_thr, n_thr;
    logic [rcw_pkg::LIMIT_W-1:0]    r_limit;
    logic [rcw_pkg::LIMIT_W-1:0]    r_dup, n_dup;
    logic [LW-1:0]                  r_last, n_last;
    logic [BASE_W-1:0]              r_base, n_base;
    logic [rcw_pkg::SLIDE_W-1:0]    r_slide, n_slide;
    logic                           r_resend, n_resend;
    rcw_pkg::t_status               r_status, n_status;

    logic                           r_out_valid;
    logic [WW-1:0]                  r_o_window;
    logic [rcw_pkg::CFG_W-1:0]      r_o_thr;
    rcw_pkg::t_phase                r_o_phase;
    logic [rcw_pkg::SEQ_OUT_W-1:0]  r_o_base;
    logic [rcw_pkg::SLIDE_W-1:0]    r_o_slide;
    logic                           r_o_resend;
    rcw_pkg::t_status               r_o_status;

    logic                           in_ready;
    logic                           in_acc;
    logic                           cfg_acc;
    logic                           div_start;
    logic                           div_done;
    logic [rcw_pkg::DIVIDEND_W-1:0] div_quot;
    logic                           need_div;
    logic                           out_load;

    rcw_pkg::t_phase                ph0;
    logic                           none_acked;
    logic [LW-1:0]                  ack17;
    logic [LW-1:0]                  ack_p1;
    logic [LW-1:0]                  base17;
    logic [LW-1:0]                  acked;
    logic [LW-1:0]                  slide_raw;
    logic                           is_new;
    logic                           is_dup;
    logic [rcw_pkg::LIMIT_W-1:0]    dup_inc;

    assign in_acc  = i_evt.valid && in_ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_evt.ready = in_ready;

    rcw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acked),
        .i_divisor  (r_window),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // event decode and state update
    always_comb begin
        ph0 = (r_phase == rcw_pkg::PH_SS && r_window >= r_thr) ? rcw_pkg::PH_CA : r_phase;
        none_acked = r_last == rcw_pkg::NONE_ACKED;
        ack17      = LW'(r_ack);
        ack_p1     = ack17 + LW'(1);
        base17     = LW'(r_base);
        acked      = none_acked ? ack_p1 : ack17 - r_last;
        is_new     = none_acked || ack17 > r_last;
        is_dup     = !none_acked && ack17 == r_last;
        slide_raw  = (ack_p1 >= base17) ? ack_p1 - base17 : '0;
        dup_inc    = (r_dup < rcw_pkg::DUP_SAT) ? r_dup + rcw_pkg::LIMIT_W'(1) : r_dup;
        need_div   = r_cmd == rcw_pkg::CMD_ACK && r_ackv && is_new && ph0 == rcw_pkg::PH_CA;

        n_phase  = r_phase;
        n_window = r_window;
        n_thr    = r_thr;
        n_dup    = r_dup;
        n_last   = r_last;
        n_base   = r_base;
        n_slide  = r_slide;
        n_resend = r_resend;
        n_status = r_status;

        unique case (r_state)
            rcw_pkg::S_CALC: begin
                n_phase  = ph0;
                n_slide  = '0;
                n_resend = 1'b0;
                n_status = rcw_pkg::ST_IGNORED;
                if (r_cmd == rcw_pkg::CMD_TIMEOUT) begin
                    n_thr    = r_window >> 1;
                    n_window = WW'(1);
                    n_phase  = rcw_pkg::PH_SS;
                    n_dup    = '0;
                    n_resend = 1'b1;
                    n_status = rcw_pkg::ST_TIMEOUT;
                end else if (r_ackv) begin
                    if (is_new) begin
                        n_status = rcw_pkg::ST_NEW;
                        priority case (ph0)
                            rcw_pkg::PH_SS: begin
                                n_window = cap_win(SW'(r_window) + SW'(acked));
                                n_resend = 1'b1;
                            end
                            rcw_pkg::PH_CA: begin
                                n_resend = 1'b1;
                            end
                            default: begin
                                n_window = cap_win(SW'(r_thr));
                                n_phase  = rcw_pkg::PH_CA;
                            end
                        endcase
                        n_last  = ack17;
                        n_dup   = '0;
                        n_slide = (slide_raw > LW'({rcw_pkg::SLIDE_W{1'b1}})) ?
                                  {rcw_pkg::SLIDE_W{1'b1}} : slide_raw[rcw_pkg::SLIDE_W-1:0];
                        n_base  = ack_p1[BASE_W-1:0];
                    end else if (is_dup) begin
                        n_status = rcw_pkg::ST_DUP;
                        if (ph0 == rcw_pkg::PH_FR) begin
                            n_window = cap_win(SW'(r_window) + SW'(1));
                            n_resend = 1'b1;
                        end else begin
                            n_dup = dup_inc;
                            if (dup_inc == r_limit) begin
                                n_phase  = rcw_pkg::PH_FR;
                                n_thr    = r_window >> 1;
                                n_window = cap_win(SW'(r_window >> 1) + SW'(rcw_pkg::RECOV_BUMP));
                                n_resend = 1'b1;
                            end
                        end
                    end
                end
            end
            rcw_pkg::S_DIV: begin
                if (div_done) begin
                    n_window = cap_win(SW'(r_window) + SW'(div_quot));
                end
            end
            default: begin
            end
        endcase

        if (cfg_acc && i_cfg.addr == rcw_pkg::CFG_INIT_THR) begin
            n_thr = i_cfg.data;
        end
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcw_pkg::S_IDLE: if (in_acc) n_state = rcw_pkg::S_CALC;
            rcw_pkg::S_CALC: n_state = need_div ? rcw_pkg::S_DIV : rcw_pkg::S_OUT;
            rcw_pkg::S_DIV:  if (div_done) n_state = rcw_pkg::S_OUT;
            rcw_pkg::S_OUT:  if (out_load) n_state = rcw_pkg::S_IDLE;
            default:         n_state = rcw_pkg::S_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        in_ready  = r_state == rcw_pkg::S_IDLE;
        div_start = r_state == rcw_pkg::S_CALC && need_div;
        out_load  = r_state == rcw_pkg::S_OUT && (!r_out_valid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcw_pkg::S_IDLE;
            r_phase     <= rcw_pkg::PH_SS;
            r_window    <= WW'(1);
            r_thr       <= rcw_pkg::THR_RESET;
            r_limit     <= rcw_pkg::LIMIT_RESET;
            r_dup       <= '0;
            r_last      <= rcw_pkg::NONE_ACKED;
            r_base      <= '0;
            r_slide     <= '0;
            r_resend    <= 1'b0;
            r_status    <= rcw_pkg::ST_IGNORED;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_window <= n_window;
            r_thr    <= n_thr;
            r_dup    <= n_dup;
            r_last   <= n_last;
            r_base   <= n_base;
            r_slide  <= n_slide;
            r_resend <= n_resend;
            r_status <= n_status;
            if (cfg_acc) begin
                unique case (i_cfg.addr)
                    rcw_pkg::CFG_DUP_LIMIT: r_limit <= i_cfg.data[rcw_pkg::LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_evt.cmd;
            r_ack  <= i_evt.ack_num;
            r_ackv <= i_evt.ack_valid;
        end
        if (out_load) begin
            r_o_window <= r_window;
            r_o_thr    <= r_thr;
            r_o_phase  <= r_phase;
            r_o_base   <= base17[rcw_pkg::SEQ_OUT_W-1:0];
            r_o_slide  <= r_slide;
            r_o_resend <= r_resend;
            r_o_status <= r_status;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.window       = r_o_window;
    assign o_res.threshold    = r_o_thr;
    assign o_res.phase        = r_o_phase;
    assign o_res.base_seq     = r_o_base;
    assign o_res.slide_count  = r_o_slide;
    assign o_res.resend_all   = r_o_resend;
    assign o_res.event_status = r_o_status;

endmodule

`default_nettype wire

>>> rtl/rcw_checker.sv
// ----------------------------------------------------------------------------
// rcw_port_checks
// Port-level checks of the congestion window controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_port_checks (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [rcw_pkg::WIN_W-1:0]      i_window,
    input  wire logic [1:0]                     i_phase,
    input  wire logic [rcw_pkg::SLIDE_W-1:0]    i_slide,
    input  wire logic                           i_resend,
    input  wire logic [1:0]                     i_status
);

    // one event in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("event accepted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_window)))
        else $error("stalled result changed");

    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_window != '0)
        else $error("window is zero");

    a_timeout_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == rcw_pkg::ST_TIMEOUT) |->
        (i_window == rcw_pkg::WIN_W'(1) && i_phase == rcw_pkg::PH_SS && i_resend))
        else $error("timeout result inconsistent");

    a_slide_new_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != rcw_pkg::ST_NEW) |-> i_slide == '0)
        else $error("slide without new ACK");

endmodule

bind reno_congestion_window rcw_port_checks u_rcw_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_evt.valid),
    .i_in_ready  (i_evt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_window    (o_res.window),
    .i_phase     (o_res.phase),
    .i_slide     (o_res.slide_count),
    .i_resend    (o_res.resend_all),
    .i_status    (o_res.event_status)
);

`default_nettype wire

>>> dv/rcw_checker.sv
// ----------------------------------------------------------------------------
// rcw_checker
// Watches the event, result and register channels of the congestion window
// controller, tracks the window state on its own, and compares every result
// request field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcw_checker import rcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rcw_evt_if   evt,
    rcw_res_if   res,
    rcw_cfg_if   cfg,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);

    typedef struct packed {
        logic [WIN_W-1:0]     window;
        logic [WIN_W-1:0]     threshold;
        t_phase               phase;
        logic [SEQ_OUT_W-1:0] base_seq;
        logic [SLIDE_W-1:0]   slide_count;
        logic                 resend_all;
        t_status              event_status;
    } window_report_t;

    window_report_t       window_reports[$];
    window_report_t       head;

    t_phase               m_phase;
    logic [WIN_W-1:0]     m_window;
    logic [WIN_W-1:0]     m_thresh;
    logic [LIMIT_W-1:0]   m_dups;
    logic [LAST_W-1:0]    m_last;
    logic [SEQ_OUT_W-1:0] m_base;
    logic [CFG_W-1:0]     m_init_thr;
    logic [LIMIT_W-1:0]   m_dup_limit;

    int                   err_count = 0;
    int                   checked_count = 0;

    function automatic logic [WIN_W-1:0] clamp_window(input int unsigned w);
        if (w > WIN_HW_MAX) begin
            return WIN_W'(WIN_HW_MAX);
        end
        if (w < 1) begin
            return WIN_W'(1);
        end
        return w[WIN_W-1:0];
    endfunction

    task automatic next_window_state(input logic c, input logic [ACK_W-1:0] a,
                                     input logic v, output window_report_t r);
        int unsigned        ack_plus;
        int unsigned        acked;
        int unsigned        s;
        logic [SLIDE_W-1:0] slide;
        logic               resend;
        t_status            st;
        logic               none;
        slide    = '0;
        resend   = 1'b0;
        st       = ST_IGNORED;
        ack_plus = int'(a) + 1;
        if (m_phase == PH_SS && m_window >= m_thresh) begin
            m_phase = PH_CA;
        end
        if (c == CMD_TIMEOUT) begin
            m_thresh = m_window >> 1;
            m_window = WIN_W'(1);
            m_phase  = PH_SS;
            m_dups   = '0;
            resend   = 1'b1;
            st       = ST_TIMEOUT;
        end else if (v) begin
            none = (m_last == NONE_ACKED);
            if (none || {1'b0, a} > m_last) begin
                acked = none ? ack_plus : int'(a) - int'(m_last);
                st    = ST_NEW;
                case (m_phase)
                    PH_SS: begin
                        m_window = clamp_window(int'(m_window) + acked);
                        resend   = 1'b1;
                    end
                    PH_CA: begin
                        m_window = clamp_window(int'(m_window) + acked / int'(m_window));
                        resend   = 1'b1;
                    end
                    default: begin
                        m_window = clamp_window(int'(m_thresh));
                        m_phase  = PH_CA;
                    end
                endcase
                m_last = {1'b0, a};
                m_dups = '0;
                s      = (ack_plus >= int'(m_base)) ? ack_plus - int'(m_base) : 0;
                slide  = (s > 32'hFFFF) ? 16'hFFFF : s[SLIDE_W-1:0];
                m_base = ack_plus[SEQ_OUT_W-1:0];
            end else if ({1'b0, a} == m_last) begin
                st = ST_DUP;
                if (m_phase == PH_FR) begin
                    m_window = clamp_window(int'(m_window) + 1);
                    resend   = 1'b1;
                end else begin
                    if (m_dups != DUP_SAT) begin
                        m_dups = m_dups + 1'b1;
                    end
                    if (m_dups == m_dup_limit) begin
                        m_phase  = PH_FR;
                        m_thresh = m_window >> 1;
                        m_window = clamp_window(int'(m_thresh) + int'(RECOV_BUMP));
                        resend   = 1'b1;
                    end
                end
            end
        end
        r.window       = m_window;
        r.threshold    = m_thresh;
        r.phase        = m_phase;
        r.base_seq     = m_base;
        r.slide_count  = slide;
        r.resend_all   = resend;
        r.event_status = st;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        window_report_t r;
        if (!i_rst_n) begin
            m_phase     = PH_SS;
            m_window    = WIN_W'(1);
            m_thresh    = THR_RESET;
            m_dups      = '0;
            m_last      = NONE_ACKED;
            m_base      = '0;
            m_init_thr  = THR_RESET;
            m_dup_limit = LIMIT_RESET;
            window_reports.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.addr)
                    CFG_INIT_THR: begin
                        m_init_thr = cfg.data;
                        m_thresh   = cfg.data;
                    end
                    CFG_DUP_LIMIT: begin
                        m_dup_limit = cfg.data[LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (res.valid && res.ready) begin
                if (window_reports.size() == 0) begin
                    err_count++;
                    $display("%0t: result with no request outstanding, actual window %0d phase %0d status %0d",
                             $time, res.window, res.phase, res.event_status);
                end else begin
                    head = window_reports.pop_front();
                    checked_count++;
                    check_field("window", head.window, res.window);
                    check_field("threshold", head.threshold, res.threshold);
                    check_field("phase", head.phase, res.phase);
                    check_field("base_seq", head.base_seq, res.base_seq);
                    check_field("slide_count", head.slide_count, res.slide_count);
                    check_field("resend_all", head.resend_all, res.resend_all);
                    check_field("event_status", head.event_status, res.event_status);
                end
            end
            if (evt.valid && evt.ready) begin
                next_window_state(evt.cmd, evt.ack_num, evt.ack_valid, r);
                window_reports.push_back(r);
            end
        end
        o_errors  <= err_count;
        o_pending <= window_reports.size();
        o_checked <= checked_count;
    end

endmodule

>>> dv/tb_reno_congestion_window.sv
// ----------------------------------------------------------------------------
// tb_reno_congestion_window
// Drives ACK and timeout event requests into the congestion window controller
// under bursty sender gaps and receiver stalls, rewrites its registers between
// phases, and reports the verdict kept by the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reno_congestion_window;
    import rcw_pkg::*;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 30;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 130;

    logic i_clk;
    logic i_rst_n;

    rcw_evt_if evt_ch();
    rcw_res_if res_ch();
    rcw_cfg_if cfg_ch();

    int err_count;
    int pending_count;
    int checked_count;

    bit hold_off_req = 1'b0;
    int burst_left   = 1;
    int hi_ack       = -1;
    int dup_streak   = 0;
    int dup_limit_now = 3;
    int n_new = 0, n_dup = 0, n_stale = 0, n_ignored = 0, n_timeout = 0, n_writes = 0;
    int cycles = 0;

    reno_congestion_window DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    rcw_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .evt       (evt_ch),
        .res       (res_ch),
        .cfg       (cfg_ch),
        .o_errors  (err_count),
        .o_pending (pending_count),
        .o_checked (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending_count);
        $display("Regression FAIL");
        $finish;
    end

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int rx_tick;
        mode         = 0;
        mode_left    = 0;
        rx_tick      = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (mode_left <= 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                rx_tick++;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= (rx_tick % 5 != 0);
                endcase
            end
        end
    end

    task automatic send_event(input logic c, input logic [ACK_W-1:0] a, input logic v);
        int gap;
        evt_ch.valid     <= 1'b1;
        evt_ch.cmd       <= c;
        evt_ch.ack_num   <= a;
        evt_ch.ack_valid <= v;
        if (c == CMD_TIMEOUT) begin
            n_timeout++;
        end else if (!v) begin
            n_ignored++;
        end else if (hi_ack < 0 || int'(a) > hi_ack) begin
            n_new++;
            hi_ack = int'(a);
        end else if (int'(a) == hi_ack) begin
            n_dup++;
        end else begin
            n_stale++;
        end
        @(posedge i_clk);
        while (!evt_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                evt_ch.valid   <= 1'b0;
                evt_ch.ack_num <= 16'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // sender pause: nothing offered until every report has come back
    task automatic drain_reports();
        evt_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        n_writes++;
        if (addr == CFG_DUP_LIMIT) begin
            dup_limit_now = int'(data[LIMIT_W-1:0]);
        end
    endtask

    task automatic send_random_event();
        int         r;
        int         step;
        logic       c;
        logic       v;
        logic [ACK_W-1:0] a;
        c = CMD_ACK;
        v = 1'b1;
        a = 16'($urandom);
        r = $urandom_range(0, 99);
        if (dup_streak > 0 && hi_ack >= 0) begin
            dup_streak--;
            a = 16'(hi_ack);
        end else if (hi_ack < 0) begin
            a = 16'($urandom_range(0, 40));
        end else if (r < 45) begin
            step = $urandom_range(0, 99);
            if (step < 70) begin
                step = $urandom_range(1, 16);
            end else if (step < 95) begin
                step = $urandom_range(17, 300);
            end else begin
                step = $urandom_range(301, 3000);
            end
            a = (hi_ack + step > 65534) ? 16'(hi_ack) : 16'(hi_ack + step);
        end else if (r < 70) begin
            dup_streak = $urandom_range(0, dup_limit_now + 1);
            a = 16'(hi_ack);
        end else if (r < 78) begin
            a = (hi_ack > 0) ? 16'($urandom_range(0, hi_ack - 1)) : 16'(hi_ack);
        end else if (r < 88) begin
            v = 1'b0;
        end else begin
            c = CMD_TIMEOUT;
            v = 1'($urandom_range(0, 1));
        end
        send_event(c, a, v);
    endtask

    initial begin
        int thr;
        int lim;
        i_rst_n          = 1'b0;
        evt_ch.valid     = 1'b0;
        evt_ch.cmd       = CMD_ACK;
        evt_ch.ack_num   = '0;
        evt_ch.ack_valid = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.addr      = CFG_INIT_THR;
        cfg_ch.data      = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults: invalid, first ACK, three dups into recovery and a fourth inflating it, exit, stale, new, timeout
        send_event(CMD_ACK, 16'hFFFF, 1'b0);
        send_event(CMD_ACK, 16'd0, 1'b1);
        repeat (4) send_event(CMD_ACK, 16'd0, 1'b1);
        send_event(CMD_ACK, 16'd40, 1'b1);
        send_event(CMD_ACK, 16'd20, 1'b1);
        send_event(CMD_ACK, 16'd300, 1'b1);
        send_event(CMD_TIMEOUT, 16'h5A5A, 1'b1);

        // max threshold, zero dup limit: window cap and dup counter saturation
        drain_reports();
        write_reg(CFG_INIT_THR, 10'd1023);
        write_reg(CFG_DUP_LIMIT, 10'd0);
        send_event(CMD_ACK, 16'd900, 1'b1);
        send_event(CMD_ACK, 16'd1600, 1'b1);
        send_event(CMD_ACK, 16'd1601, 1'b1);
        repeat (16) send_event(CMD_ACK, 16'd1601, 1'b1);

        // min threshold, limit one
        drain_reports();
        write_reg(CFG_INIT_THR, 10'd1);
        write_reg(CFG_DUP_LIMIT, 10'd1);
        send_event(CMD_ACK, 16'd1601, 1'b1);
        send_event(CMD_ACK, 16'd1700, 1'b1);
        send_event(CMD_ACK, 16'd1700, 1'b1);
        send_event(CMD_TIMEOUT, 16'h0000, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_reports();
            case (p)
                1: begin
                    thr = 1023;
                    lim = 15;
                end
                2: begin
                    thr = 1;
                    lim = 1;
                end
                default: begin
                    thr = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                      : $urandom_range(1, 1023);
                    lim = $urandom_range(1, 6);
                end
            endcase
            write_reg(CFG_INIT_THR, CFG_W'(thr));
            write_reg(CFG_DUP_LIMIT, CFG_W'(lim));
            dup_streak = 0;
            if (p == 1) begin
                hold_off_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_random_event();
        end

        // top of the sequence space: base wraps to zero
        drain_reports();
        send_event(CMD_ACK, 16'hFFFF, 1'b1);
        send_event(CMD_ACK, 16'hFFFF, 1'b1);
        send_event(CMD_ACK, 16'd100, 1'b1);
        send_event(CMD_TIMEOUT, 16'hFFFF, 1'b1);
        send_event(CMD_ACK, 16'hFFFF, 1'b1);
        drain_reports();

        $display("Covered %0d events: %0d new, %0d duplicate, %0d stale, %0d invalid, %0d timeouts",
                 n_new + n_dup + n_stale + n_ignored + n_timeout,
                 n_new, n_dup, n_stale, n_ignored, n_timeout);
        $display("Checked %0d results across %0d register writes, one long receiver hold-off",
                 checked_count, n_writes);
        if (err_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
